[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pdl_pkg.sv]
// Types and codes of the password door lock controller.
`default_nettype none
package pdl_pkg;

  // request kinds
  localparam logic [1:0] FUNC_PWD    = 2'd0;
  localparam logic [1:0] FUNC_CHOICE = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  // controller phases
  localparam logic [2:0] PH_SET_FIRST  = 3'd0;
  localparam logic [2:0] PH_SET_SECOND = 3'd1;
  localparam logic [2:0] PH_MENU       = 3'd2;
  localparam logic [2:0] PH_ENTER      = 3'd3;
  localparam logic [2:0] PH_OPEN       = 3'd4;
  localparam logic [2:0] PH_LOCK       = 3'd5;

  // reported steps
  localparam logic [2:0] STEP_SET   = 3'd0;
  localparam logic [2:0] STEP_MENU  = 3'd1;
  localparam logic [2:0] STEP_ENTER = 3'd2;
  localparam logic [2:0] STEP_OPEN  = 3'd3;
  localparam logic [2:0] STEP_WRONG = 3'd4;

  // motor commands
  localparam logic [1:0] MOTOR_STOP = 2'd0;
  localparam logic [1:0] MOTOR_CW   = 2'd1;
  localparam logic [1:0] MOTOR_CCW  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_MAX_ATTEMPTS  = 3'd0;
  localparam logic [2:0] REG_OPEN_STOP     = 3'd1;
  localparam logic [2:0] REG_REVERSE_START = 3'd2;
  localparam logic [2:0] REG_CLOSE_DONE    = 3'd3;
  localparam logic [2:0] REG_LOCKOUT       = 3'd4;

  typedef struct packed {
    logic [2:0] max_attempts;
    logic [3:0] open_stop_tick;
    logic [3:0] reverse_start_tick;
    logic [3:0] close_done_tick;
    logic [3:0] lockout_ticks;
  } cfg_t;

  // report_valid sits in the lowest bit
  typedef struct packed {
    logic       buzzer_active;
    logic [1:0] motor_drive;
    logic [2:0] next_step;
    logic       report_valid;
  } res_t;

endpackage
`default_nettype wire

[rtl/password_door_lock_controller_top.sv]
// Top level of the password door lock controller.
//
// Input stream: s_tuser carries the request kind (password byte, menu
// choice, timer tick), s_tdata the byte. Output stream: one result per
// accepted request with the report flag, next step, motor command and
// buzzer state after that request.
// The result is valid in the cycle after the request is taken.
// Throughput: one request per cycle unless stalled; all state updates
// happen in one pass of compare and select logic ahead of a single
// result register. Input ready is high whenever the result register is
// empty or being drained in the same cycle, so a stalled receiver holds
// the result and stops further requests only while it holds one.
// Reset (rst, synchronous) returns to the first password entry, motor
// stopped, buzzer off, registers at their defaults; no result is pending.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr at once;
// indexes beyond the last register are ignored.
`default_nettype none
`include "assert_macros.svh"
module password_door_lock_controller_top #(
  parameter int PASSWORD_LENGTH = 5
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_addr,
  input  wire logic [3:0] cfg_wdata,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic [1:0] s_tuser,   // [1:0] func
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata    // [0] report_valid, [3:1] next_step,
                                     // [5:4] motor_drive, [6] buzzer_active
);
  import pdl_pkg::*;

  cfg_t cfg;
  res_t res;
  logic take;
  logic idx_ok;

  assign take = s_tvalid && s_tready;

  pdl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pdl_core #(
    .PASSWORD_LENGTH (PASSWORD_LENGTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .func      (s_tuser),
    .data_byte (s_tdata),
    .res       (res),
    .idx_ok    (idx_ok)
  );

  pdl_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .res      (res),
    .free     (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  `ASSERT_NEXT(a_result_follows, clk, rst, take, m_tvalid, "accepted request gave no result")
  `ASSERT_ALWAYS(a_no_buzz_while_moving, clk, rst, !(m_tvalid && m_tdata[6] && m_tdata[5:4] != MOTOR_STOP), "buzzer on while motor runs")
  `ASSERT_ALWAYS(a_step_needs_report, clk, rst, !(m_tvalid && !m_tdata[0] && m_tdata[3:1] != STEP_SET), "step without report")
  `ASSERT_ALWAYS(a_index_range, clk, rst, idx_ok, "byte index past password length")

endmodule
`default_nettype wire

[rtl/pdl_cfg_regs.sv]
// Configuration registers of the door lock controller.
`default_nettype none
module pdl_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [3:0]   cfg_wdata,
  output pdl_pkg::cfg_t     cfg
);
  import pdl_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_attempts       <= 3'd3;
      cfg.open_stop_tick     <= 4'd5;
      cfg.reverse_start_tick <= 4'd6;
      cfg.close_done_tick    <= 4'd11;
      cfg.lockout_ticks      <= 4'd10;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_ATTEMPTS:  cfg.max_attempts       <= cfg_wdata[2:0];
        REG_OPEN_STOP:     cfg.open_stop_tick     <= cfg_wdata;
        REG_REVERSE_START: cfg.reverse_start_tick <= cfg_wdata;
        REG_CLOSE_DONE:    cfg.close_done_tick    <= cfg_wdata;
        REG_LOCKOUT:       cfg.lockout_ticks      <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/pdl_core.sv]
// Phase sequencer, password buffers and tick timing of the door lock.
`default_nettype none
module pdl_core #(
  parameter int PASSWORD_LENGTH = 5
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire pdl_pkg::cfg_t cfg,
  input  wire logic         take,
  input  wire logic [1:0]   func,
  input  wire logic [7:0]   data_byte,
  output pdl_pkg::res_t     res,
  output logic              idx_ok
);
  import pdl_pkg::*;

  localparam int IW = (PASSWORD_LENGTH > 1) ? $clog2(PASSWORD_LENGTH) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(PASSWORD_LENGTH - 1);

  logic [7:0]    first_entry     [PASSWORD_LENGTH];
  logic [7:0]    stored_password [PASSWORD_LENGTH];

  logic [2:0]    phase, phase_next;
  logic [IW-1:0] byte_index, byte_index_next;
  logic          mismatch_seen, mismatch_seen_next;
  logic [2:0]    attempt_count, attempt_count_next;
  logic          chosen_action, chosen_action_next;
  logic [3:0]    tick_count, tick_count_next;
  logic [1:0]    motor_state, motor_state_next;
  logic          buzzer_state, buzzer_state_next;

  logic          byte_take;
  logic          cmp_ne;
  logic [2:0]    attempt_inc;
  logic [3:0]    tick_inc;
  logic          valid;
  logic [2:0]    step;

  assign byte_take   = take && (func == FUNC_PWD) &&
                       (phase inside {PH_SET_FIRST, PH_SET_SECOND, PH_ENTER});
  assign attempt_inc = attempt_count + 3'd1;
  assign tick_inc    = tick_count + 4'd1;

  always_comb begin
    case (phase)
      PH_SET_SECOND: cmp_ne = first_entry[byte_index] != data_byte;
      PH_ENTER:      cmp_ne = stored_password[byte_index] != data_byte;
      default:       cmp_ne = 1'b0;
    endcase
  end

  always_comb begin
    phase_next         = phase;
    byte_index_next    = byte_index;
    mismatch_seen_next = mismatch_seen;
    attempt_count_next = attempt_count;
    chosen_action_next = chosen_action;
    tick_count_next    = tick_count;
    motor_state_next   = motor_state;
    buzzer_state_next  = buzzer_state;
    valid              = 1'b0;
    step               = STEP_SET;

    if (byte_take) begin
      mismatch_seen_next = ((byte_index == '0) ? 1'b0 : mismatch_seen) | cmp_ne;
      byte_index_next    = (byte_index == LAST_IDX) ? '0 : byte_index + IW'(1);
      if (byte_index == LAST_IDX) begin
        case (phase)
          PH_SET_FIRST: phase_next = PH_SET_SECOND;
          PH_SET_SECOND: begin
            valid = 1'b1;
            if (!mismatch_seen_next) begin
              phase_next = PH_MENU;
              step       = STEP_MENU;
            end else begin
              phase_next = PH_SET_FIRST;
            end
          end
          default: begin
            valid = 1'b1;
            if (!mismatch_seen_next) begin
              attempt_count_next = '0;
              if (chosen_action) begin
                phase_next       = PH_OPEN;
                step             = STEP_OPEN;
                tick_count_next  = '0;
                motor_state_next = MOTOR_CW;
              end else begin
                phase_next = PH_SET_FIRST;
              end
            end else if (attempt_inc < cfg.max_attempts) begin
              attempt_count_next = attempt_inc;
              step               = STEP_ENTER;
            end else begin
              attempt_count_next = '0;
              phase_next         = PH_LOCK;
              step               = STEP_WRONG;
              tick_count_next    = '0;
              buzzer_state_next  = 1'b1;
            end
          end
        endcase
      end
    end else if (take && func == FUNC_CHOICE && phase == PH_MENU) begin
      chosen_action_next = data_byte != 8'd0;
      byte_index_next    = '0;
      phase_next         = PH_ENTER;
    end else if (take && func == FUNC_TICK && phase == PH_OPEN) begin
      tick_count_next = tick_inc;
      // first matching compare wins
      if (tick_inc == cfg.open_stop_tick) begin
        motor_state_next = MOTOR_STOP;
      end else if (tick_inc == cfg.reverse_start_tick) begin
        motor_state_next = MOTOR_CCW;
      end else if (tick_inc == cfg.close_done_tick) begin
        motor_state_next = MOTOR_STOP;
        tick_count_next  = '0;
        phase_next       = PH_MENU;
      end
    end else if (take && func == FUNC_TICK && phase == PH_LOCK) begin
      tick_count_next = tick_inc;
      if (tick_inc == cfg.lockout_ticks) begin
        buzzer_state_next = 1'b0;
        tick_count_next   = '0;
        phase_next        = PH_MENU;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SET_FIRST;
      byte_index    <= '0;
      mismatch_seen <= 1'b0;
      attempt_count <= '0;
      chosen_action <= 1'b0;
      tick_count    <= '0;
      motor_state   <= MOTOR_STOP;
      buzzer_state  <= 1'b0;
    end else begin
      phase         <= phase_next;
      byte_index    <= byte_index_next;
      mismatch_seen <= mismatch_seen_next;
      attempt_count <= attempt_count_next;
      chosen_action <= chosen_action_next;
      tick_count    <= tick_count_next;
      motor_state   <= motor_state_next;
      buzzer_state  <= buzzer_state_next;
    end
  end

  // The second entry goes straight into the stored password; a mismatch
  // sends the phase back to the first entry, so a partial copy is never read.
  always_ff @(posedge clk) begin
    if (byte_take && phase == PH_SET_FIRST) first_entry[byte_index] <= data_byte;
    if (byte_take && phase == PH_SET_SECOND) stored_password[byte_index] <= data_byte;
  end

  assign res.report_valid  = valid;
  assign res.next_step     = step;
  assign res.motor_drive   = motor_state_next;
  assign res.buzzer_active = buzzer_state_next;
  assign idx_ok            = byte_index <= LAST_IDX;

endmodule
`default_nettype wire

[rtl/pdl_out_reg.sv]
// Result register between the controller and the output stream.
`default_nettype none
module pdl_out_reg (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire pdl_pkg::res_t res,
  output logic              free,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [7:0]        m_tdata
);
  import pdl_pkg::*;

  res_t res_q;

  // space opens when the register is empty or the held result leaves in this cycle
  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= load || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_q <= res;
  end

  assign m_tdata = {1'b0, res_q};

endmodule
`default_nettype wire

[tb/password_door_lock_controller_top_tb.sv]
// Self-checking stream testbench for the password door lock controller.
`default_nettype none
module password_door_lock_controller_top_tb;
  import pdl_pkg::*;

  localparam int PWD_LEN = 5;
  localparam int RAND_REQS = 1400;
  localparam int SETTING_SPAN = 150;
  localparam int IDLE_LIMIT = 5000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [1:0] func;
    logic [7:0] data;      // register value in the low bits for ROW_REG
    logic [2:0] reg_idx;
    bit         known;
    res_t       result;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [3:0] cfg_wdata = '0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  password_door_lock_controller_top #(.PASSWORD_LENGTH(PWD_LEN)) uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // lock state as the testbench sees it
  cfg_t       lock_cfg = '{3'd3, 4'd5, 4'd6, 4'd11, 4'd10};
  logic [2:0] door_phase = PH_SET_FIRST;
  logic [7:0] door_saved [PWD_LEN] = '{default: 8'h00};
  logic [7:0] door_first [PWD_LEN] = '{default: 8'h00};
  int         door_idx = 0;
  logic       door_miss = 1'b0;
  logic [2:0] door_tries = '0;
  logic       door_open_sel = 1'b0;
  logic [3:0] door_ticks = '0;
  logic [1:0] door_motor = MOTOR_STOP;
  logic       door_buzz = 1'b0;

  res_t       expected_status [$];
  dir_row_t   directed_rows [$];
  logic [7:0] frame_plan [PWD_LEN] = '{default: 8'h00};
  int         fail_count = 0;
  int         src_burst = 0;
  int         sink_burst = 0;
  int         sink_wait = 0;
  int         idle_cycles = 0;

  function automatic res_t mk_status(logic v, logic [2:0] step, logic [1:0] motor, logic buzz);
    res_t r;
    r.report_valid = v;
    r.next_step = step;
    r.motor_drive = motor;
    r.buzzer_active = buzz;
    return r;
  endfunction

  // Applies one request to the lock state and returns the status it yields.
  function automatic res_t advance_lock(logic [1:0] f, logic [7:0] b);
    res_t r;
    int   i;
    r = '0;
    if (f == FUNC_PWD && (door_phase == PH_SET_FIRST || door_phase == PH_SET_SECOND ||
                          door_phase == PH_ENTER)) begin
      i = door_idx % PWD_LEN;
      if (i == 0) door_miss = 1'b0;
      if (door_phase == PH_SET_FIRST) door_first[i] = b;
      else if (door_phase == PH_SET_SECOND) door_miss |= (door_first[i] != b);
      else door_miss |= (door_saved[i] != b);
      door_idx = (i + 1 >= PWD_LEN) ? 0 : i + 1;
      if (i + 1 >= PWD_LEN) begin
        r.report_valid = 1'b1;
        if (door_phase == PH_SET_FIRST) begin
          door_phase = PH_SET_SECOND;
          r.report_valid = 1'b0;
        end else if (door_phase == PH_SET_SECOND) begin
          if (!door_miss) begin
            door_saved = door_first;
            door_phase = PH_MENU;
            r.next_step = STEP_MENU;
          end else begin
            door_phase = PH_SET_FIRST;
            r.next_step = STEP_SET;
          end
        end else begin
          door_tries = door_tries + 3'd1;
          if (!door_miss) begin
            door_tries = '0;
            if (door_open_sel) begin
              door_phase = PH_OPEN;
              r.next_step = STEP_OPEN;
              door_ticks = '0;
              door_motor = MOTOR_CW;
            end else begin
              door_phase = PH_SET_FIRST;
              r.next_step = STEP_SET;
            end
          end else if (door_tries < lock_cfg.max_attempts) begin
            r.next_step = STEP_ENTER;
          end else begin
            door_tries = '0;
            door_phase = PH_LOCK;
            r.next_step = STEP_WRONG;
            door_ticks = '0;
            door_buzz = 1'b1;
          end
        end
      end
    end else if (f == FUNC_CHOICE && door_phase == PH_MENU) begin
      door_open_sel = (b != 8'h00);
      door_idx = 0;
      door_phase = PH_ENTER;
    end else if (f == FUNC_TICK && door_phase == PH_OPEN) begin
      door_ticks = door_ticks + 4'd1;
      // stop tick wins over reverse tick, which wins over close tick
      if (door_ticks == lock_cfg.open_stop_tick) begin
        door_motor = MOTOR_STOP;
      end else if (door_ticks == lock_cfg.reverse_start_tick) begin
        door_motor = MOTOR_CCW;
      end else if (door_ticks == lock_cfg.close_done_tick) begin
        door_motor = MOTOR_STOP;
        door_ticks = '0;
        door_phase = PH_MENU;
      end
    end else if (f == FUNC_TICK && door_phase == PH_LOCK) begin
      door_ticks = door_ticks + 4'd1;
      if (door_ticks == lock_cfg.lockout_ticks) begin
        door_buzz = 1'b0;
        door_ticks = '0;
        door_phase = PH_MENU;
      end
    end
    r.motor_drive = door_motor;
    r.buzzer_active = door_buzz;
    return r;
  endfunction

  // mostly zero, some short, a few long, and now and then a long run of zeros
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [3:0] rand_tick();
    case ($urandom_range(0, 3))
      0: return 4'd0;
      1: return 4'd15;
      default: return 4'($urandom_range(1, 14));
    endcase
  endfunction

  task automatic add_req(logic [1:0] f, logic [7:0] b);
    directed_rows.push_back('{ROW_ITEM, f, b, 3'd0, 1'b0, res_t'(0)});
  endtask

  task automatic add_known(logic [1:0] f, logic [7:0] b, res_t r);
    directed_rows.push_back('{ROW_ITEM, f, b, 3'd0, 1'b1, r});
  endtask

  task automatic add_reg(logic [2:0] idx, logic [3:0] v);
    directed_rows.push_back('{ROW_REG, FUNC_PWD, {4'd0, v}, idx, 1'b0, res_t'(0)});
  endtask

  task automatic send_req(logic [1:0] f, logic [7:0] b, bit known, res_t known_res);
    res_t r;
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    r = advance_lock(f, b);
    expected_status.push_back(known ? known_res : r);
  endtask

  task automatic source_gap();
    int n;
    n = pick_gap(src_burst);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // sender holds off until every status has come back
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [3:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_ATTEMPTS:  lock_cfg.max_attempts = v[2:0];
      REG_OPEN_STOP:     lock_cfg.open_stop_tick = v;
      REG_REVERSE_START: lock_cfg.reverse_start_tick = v;
      REG_CLOSE_DONE:    lock_cfg.close_done_tick = v;
      REG_LOCKOUT:       lock_cfg.lockout_ticks = v;
      default: ;
    endcase
  endtask

  // Well-formed frames with random content, plus some noise.
  task automatic choose_request(output logic [1:0] f, output logic [7:0] b);
    int k;
    int j;
    k = door_idx % PWD_LEN;
    if ($urandom_range(0, 99) < 7) begin
      f = 2'($urandom_range(0, 3));
      b = 8'($urandom_range(0, 255));
    end else begin
      case (door_phase)
        PH_SET_FIRST, PH_SET_SECOND, PH_ENTER: begin
          if (k == 0) begin
            if (door_phase == PH_SET_FIRST) begin
              for (j = 0; j < PWD_LEN; j++) frame_plan[j] = rand_byte();
            end else begin
              if (door_phase == PH_SET_SECOND) frame_plan = door_first;
              else frame_plan = door_saved;
              if ($urandom_range(0, 99) < 30) begin
                j = $urandom_range(0, PWD_LEN - 1);
                frame_plan[j] = frame_plan[j] ^ 8'($urandom_range(1, 255));
              end
            end
          end
          f = FUNC_PWD;
          b = frame_plan[k];
        end
        PH_MENU: begin
          f = FUNC_CHOICE;
          b = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        end
        default: begin
          f = FUNC_TICK;
          b = 8'($urandom_range(0, 255));
        end
      endcase
    end
  endtask

  initial begin : stimulus
    logic [7:0] pin [PWD_LEN];
    res_t       idle_st;
    dir_row_t   row;
    logic [1:0] f;
    logic [7:0] b;
    logic [3:0] set_vals [5];
    int         k;
    int         n;

    pin = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h81};
    idle_st = mk_status(1'b0, STEP_SET, MOTOR_STOP, 1'b0);

    // requests of the wrong kind are ignored
    add_known(FUNC_TICK, 8'h3C, idle_st);
    add_known(FUNC_UNUSED, 8'hC3, idle_st);
    for (k = 0; k < PWD_LEN; k++) add_known(FUNC_PWD, pin[k], idle_st);
    for (k = 0; k < PWD_LEN; k++)
      add_known(FUNC_PWD, pin[k],
                (k == PWD_LEN - 1) ? mk_status(1'b1, STEP_MENU, MOTOR_STOP, 1'b0) : idle_st);
    add_known(FUNC_PWD, 8'h77, idle_st);
    add_req(FUNC_CHOICE, 8'hFF);
    // wrong last byte with the default attempt limit
    for (k = 0; k < PWD_LEN; k++)
      add_known(FUNC_PWD, (k == PWD_LEN - 1) ? 8'h80 : pin[k],
                (k == PWD_LEN - 1) ? mk_status(1'b1, STEP_ENTER, MOTOR_STOP, 1'b0) : idle_st);
    // zero limit; stop and reverse on the same tick
    add_reg(REG_MAX_ATTEMPTS, 4'd0);
    add_reg(REG_OPEN_STOP, 4'd1);
    add_reg(REG_REVERSE_START, 4'd1);
    add_reg(REG_CLOSE_DONE, 4'd2);
    add_reg(REG_LOCKOUT, 4'd1);
    for (k = 0; k < PWD_LEN; k++)
      add_known(FUNC_PWD, (k == 0) ? 8'h01 : pin[k],
                (k == PWD_LEN - 1) ? mk_status(1'b1, STEP_WRONG, MOTOR_STOP, 1'b1) : idle_st);
    add_known(FUNC_TICK, 8'h00, idle_st);
    add_req(FUNC_CHOICE, 8'h01);
    for (k = 0; k < PWD_LEN; k++)
      add_known(FUNC_PWD, pin[k],
                (k == PWD_LEN - 1) ? mk_status(1'b1, STEP_OPEN, MOTOR_CW, 1'b0) : idle_st);
    add_req(FUNC_TICK, 8'hFF);
    add_req(FUNC_TICK, 8'h55);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (directed_rows.size() != 0) begin
      row = directed_rows.pop_front();
      if (row.kind == ROW_REG) begin
        wait_quiet();
        write_reg(row.reg_idx, row.data[3:0]);
      end else begin
        send_req(row.func, row.data, row.known, row.result);
        source_gap();
      end
    end

    for (n = 0; n < RAND_REQS; n++) begin
      if (n % SETTING_SPAN == 0) begin
        case (n / SETTING_SPAN)
          0: set_vals = '{4'd0, 4'd0, 4'd0, 4'd15, 4'd0};
          1: set_vals = '{4'd7, 4'd15, 4'd15, 4'd0, 4'd15};
          2: set_vals = '{4'd3, 4'd5, 4'd6, 4'd11, 4'd10};
          default: begin
            set_vals[0] = 4'($urandom_range(0, 7));
            set_vals[1] = rand_tick();
            set_vals[2] = rand_tick();
            set_vals[4] = rand_tick();
            // close tick must differ from the stop and reverse ticks or the door never closes
            do set_vals[3] = rand_tick();
            while (set_vals[3] == set_vals[1] || set_vals[3] == set_vals[2]);
          end
        endcase
        wait_quiet();
        write_reg(REG_MAX_ATTEMPTS, set_vals[0]);
        write_reg(REG_OPEN_STOP, set_vals[1]);
        write_reg(REG_REVERSE_START, set_vals[2]);
        write_reg(REG_CLOSE_DONE, set_vals[3]);
        write_reg(REG_LOCKOUT, set_vals[4]);
      end
      choose_request(f, b);
      send_req(f, b, 1'b0, res_t'(0));
      source_gap();
    end

    wait_quiet();
    repeat (4) @(posedge clk);
    if (expected_status.size() != 0) begin
      $error("%0d status words never arrived", expected_status.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (sink_wait > 0) begin
      sink_wait = sink_wait - 1;
      m_tready <= 1'b0;
    end else begin
      sink_wait = pick_gap(sink_burst);
      m_tready <= (sink_wait == 0);
      if (sink_wait > 0) sink_wait = sink_wait - 1;
    end
  end

  always @(posedge clk) begin : status_check
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'(m_tdata[6:0]);
      if (expected_status.size() == 0) begin
        $error("status 0x%0h with no request outstanding", m_tdata);
        fail_count++;
      end else begin
        want = expected_status.pop_front();
        if (got.report_valid !== want.report_valid) begin
          $error("report_valid: expected %0d, got %0d", want.report_valid, got.report_valid);
          fail_count++;
        end
        if (got.next_step !== want.next_step) begin
          $error("next_step: expected %0d, got %0d", want.next_step, got.next_step);
          fail_count++;
        end
        if (got.motor_drive !== want.motor_drive) begin
          $error("motor_drive: expected %0d, got %0d", want.motor_drive, got.motor_drive);
          fail_count++;
        end
        if (got.buzzer_active !== want.buzzer_active) begin
          $error("buzzer_active: expected %0d, got %0d", want.buzzer_active,
                 got.buzzer_active);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $error("no request or status moved for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire
